@@ src/bfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam int FRAME_TOTAL   = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (FRAME_TOTAL + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_AW        = $clog2(MAP_WORD_BITS);

  localparam int FRAME_W = 13;  // counts, range registers, run bounds
  localparam int GRANT_W = 12;
  localparam int OP_W    = 2;
  localparam int CFG_AW  = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RANGE_LIMIT = 2'd1;

  typedef struct packed {
    logic                     we;
    logic [WORD_AW-1:0]       addr;
    logic [MAP_WORD_BITS-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ src/bitmap_frame_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// First-fit page frame allocator over a 4096-frame bitmap (64 words of 64 bits).
// Channels: requests (op, run_first, frame_count) on in_valid/in_ready, one
// result (status, granted_frame) per request on out_valid/out_ready, and a
// config write channel (cfg_index, cfg_data) that is always ready and loads
// range_start (index 0) or range_limit (index 1); other indexes are dropped.
// One request is in work at a time; in_ready is high only while idle.
// A zero-length allocate or an unknown op goes straight to the result. Free
// and mark do a read-modify-write per touched bitmap word (address, read
// wait, write). Allocate reads one word at a time while a free run extends;
// the highest used frame inside the needed window restarts the search at the
// frame past it, and the found run is then marked as mark does. The bitmap
// word port takes one access per cycle and has a registered read.
// Reset clears all bits at once through per-word valid flags and loads
// range_start 0, range_limit 4096. A result waits in the output register while
// the receiver stalls; the next request may be accepted meanwhile, and its
// result is held back until the previous one is taken.
module bitmap_frame_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfa_pkg::CFG_AW-1:0]    cfg_index,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bfa_pkg::OP_W-1:0]      op,
  input  wire logic [bfa_pkg::GRANT_W-1:0]   run_first,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   frame_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               status,
  output logic      [bfa_pkg::GRANT_W-1:0]   granted_frame
);

  localparam int FW = bfa_pkg::FRAME_W;
  localparam int WB = bfa_pkg::MAP_WORD_BITS;
  localparam int AW = bfa_pkg::WORD_AW;
  localparam int BW = bfa_pkg::BIT_AW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_WAIT, ST_SCAN, ST_WR_START, ST_WR_WAIT, ST_WR_MOD, ST_RESP
  } state_t;

  // End of a run, clipped to the bitmap size.
  function automatic logic [FW-1:0] clip_end(input logic [FW-1:0] first,
                                              input logic [FW-1:0] cnt);
    logic [FW:0] sum;
    sum = {1'b0, first} + {1'b0, cnt};
    if (sum > (FW+1)'(bfa_pkg::FRAME_TOTAL)) begin
      return FW'(bfa_pkg::FRAME_TOTAL);
    end
    return sum[FW-1:0];
  endfunction

  function automatic logic [BW-1:0] top_bit(input logic [WB-1:0] v);
    logic [BW-1:0] idx;
    idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (v[i]) begin
        idx = BW'(i);
      end
    end
    return idx;
  endfunction

  state_t                 state;
  logic [FW-1:0]          range_start;
  logic [FW-1:0]          range_limit;
  logic [FW-1:0]          count_r;
  logic [FW-1:0]          cand;
  logic [FW-1:0]          len;
  logic [BW-1:0]          bitp;
  logic [AW-1:0]          word;
  logic [FW-1:0]          wr_cur;
  logic [FW-1:0]          wr_end;
  logic                   set_r;
  logic                   res_status;
  logic [bfa_pkg::GRANT_W-1:0] res_grant;

  bfa_pkg::mem_req_t      mem_req;
  logic [WB-1:0]          rd_word;

  logic [FW-1:0]          need;
  logic [FW:0]            win_end;
  logic [WB-1:0]          win_mask;
  logic [WB-1:0]          used;
  logic [BW-1:0]          used_top;
  logic [WB-1:0]          wr_mask;
  logic                   over_limit;
  logic                   resp_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign resp_fire = (state == ST_RESP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_limit <= FW'(bfa_pkg::FRAME_TOTAL);
    end else if (cfg_valid) begin
      if (cfg_index == bfa_pkg::REG_RANGE_START) begin
        range_start <= cfg_data;
      end else if (cfg_index == bfa_pkg::REG_RANGE_LIMIT) begin
        range_limit <= cfg_data;
      end
    end
  end

  always_comb begin
    need     = count_r - len;
    win_end  = {{(FW+1-BW){1'b0}}, bitp} + {1'b0, need};
    for (int i = 0; i < WB; i++) begin
      win_mask[i] = (BW'(i) >= bitp) && ((FW+1)'(i) < win_end);
      wr_mask[i]  = (BW'(i) >= wr_cur[BW-1:0]) &&
                    ({{(FW-AW-BW){1'b0}}, word, BW'(i)} < wr_end);
    end
    used       = rd_word & win_mask;
    used_top   = top_bit(used);
    over_limit = ({1'b0, cand} + {1'b0, count_r}) > {1'b0, range_limit};
  end

  always_comb begin
    mem_req.we    = (state == ST_WR_MOD);
    mem_req.addr  = word;
    mem_req.wdata = (rd_word & ~wr_mask) | (set_r ? wr_mask : '0);
  end

  bfa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (resp_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            count_r    <= frame_count;
            res_status <= 1'b0;
            res_grant  <= (op == bfa_pkg::OP_ALLOC && frame_count == '0) ?
                          range_start[bfa_pkg::GRANT_W-1:0] : '0;
            wr_cur     <= {1'b0, run_first};
            wr_end     <= clip_end({1'b0, run_first}, frame_count);
            set_r      <= (op != bfa_pkg::OP_FREE);
            if (op == bfa_pkg::OP_ALLOC) begin
              if (frame_count == '0) begin
                state <= ST_RESP;
              end else begin
                cand  <= range_start;
                len   <= '0;
                state <= ST_CHECK;
              end
            end else if (op == bfa_pkg::OP_FREE || op == bfa_pkg::OP_MARK) begin
              state <= ST_WR_START;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_CHECK: begin
          // the scan begins a run at cand; len counts free frames found so far
          if (over_limit) begin
            res_status <= 1'b1;
            state      <= ST_RESP;
          end else if (cand >= FW'(bfa_pkg::FRAME_TOTAL)) begin
            res_grant <= cand[bfa_pkg::GRANT_W-1:0];
            state     <= ST_RESP;
          end else begin
            word  <= cand[AW+BW-1:BW];
            bitp  <= cand[BW-1:0];
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (|used) begin
            cand  <= {{(FW-AW-BW){1'b0}}, word, used_top} + FW'(1);
            len   <= '0;
            state <= ST_CHECK;
          end else if (win_end <= (FW+1)'(WB) || word == AW'(bfa_pkg::MAP_WORDS - 1)) begin
            // run complete, or it runs past the bitmap where frames are free
            res_grant <= cand[bfa_pkg::GRANT_W-1:0];
            wr_cur    <= cand;
            wr_end    <= clip_end(cand, count_r);
            set_r     <= 1'b1;
            state     <= ST_WR_START;
          end else begin
            len   <= len + FW'(WB) - {{(FW-BW){1'b0}}, bitp};
            word  <= word + AW'(1);
            bitp  <= '0;
            state <= ST_WAIT;
          end
        end
        ST_WR_START: begin
          if (wr_cur >= wr_end) begin
            state <= ST_RESP;
          end else begin
            word  <= wr_cur[AW+BW-1:BW];
            state <= ST_WR_WAIT;
          end
        end
        ST_WR_WAIT: begin
          state <= ST_WR_MOD;
        end
        ST_WR_MOD: begin
          wr_cur <= {{(FW-AW-BW){1'b0}}, word, {BW{1'b0}}} + FW'(WB);
          state  <= ST_WR_START;
        end
        ST_RESP: begin
          if (resp_fire) begin
            status        <= res_status;
            granted_frame <= res_status ? '0 : res_grant;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fail_zero_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> granted_frame == '0)
    else $error("failed allocate carries a nonzero frame");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_scan_short_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> len < count_r)
    else $error("scan continues past a complete run");

  a_write_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR_MOD |-> wr_cur < wr_end && wr_mask != '0)
    else $error("bitmap write outside the run");

  a_cand_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && $past(state) == ST_SCAN |-> cand > $past(cand))
    else $error("search restart did not advance");

endmodule

`default_nettype wire

@@ src/bfa_bitmap.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bitmap word store: one address per cycle, registered read, per-word valid
// bits so a word never written since reset reads as all free.
module bfa_bitmap (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bfa_pkg::mem_req_t                 req,
  output logic       [bfa_pkg::MAP_WORD_BITS-1:0] rd_word
);

  logic [bfa_pkg::MAP_WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0]     valid;
  logic [bfa_pkg::MAP_WORD_BITS-1:0] rd_data;
  logic                              rd_valid;

  always_ff @(posedge clk) begin
    rd_data <= mem[req.addr];
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[req.addr];
      if (req.we) begin
        valid[req.addr] <= 1'b1;
      end
    end
  end

  assign rd_word = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire
